[rtl/core/cmfuv_pkg.sv]
// Package with the face codes, the per-face minor-axis tables and the shared control types.
`timescale 1ns / 1ps

package cmfuv_pkg;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [2:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_e;

  typedef struct packed {
    face_e face;
    logic  degenerate;
  } ctrl_t;

  // Minor axis that drives u on each face.
  function automatic axis_e face_u_axis(face_e f);
    unique case (f) inside
      FACE_POS_X, FACE_NEG_X: return AXIS_Z;
      FACE_POS_Y, FACE_NEG_Y, FACE_POS_Z, FACE_NEG_Z: return AXIS_X;
      default: return AXIS_X;
    endcase
  endfunction

  // Minor axis that drives v on each face.
  function automatic axis_e face_v_axis(face_e f);
    unique case (f) inside
      FACE_POS_Y, FACE_NEG_Y: return AXIS_Z;
      FACE_POS_X, FACE_NEG_X, FACE_POS_Z, FACE_NEG_Z: return AXIS_Y;
      default: return AXIS_Y;
    endcase
  endfunction

  function automatic logic face_u_neg(face_e f);
    unique case (f) inside
      FACE_NEG_X, FACE_POS_Z: return 1'b1;
      FACE_POS_X, FACE_POS_Y, FACE_NEG_Y, FACE_NEG_Z: return 1'b0;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic face_v_neg(face_e f);
    unique case (f) inside
      FACE_NEG_Y: return 1'b1;
      FACE_POS_X, FACE_NEG_X, FACE_POS_Y, FACE_POS_Z, FACE_NEG_Z: return 1'b0;
      default: return 1'b0;
    endcase
  endfunction

endpackage

[rtl/core/cmfuv_front.sv]
// Front stage: major-axis selection, face classification and divider operand setup.
`timescale 1ns / 1ps

module cmfuv_front #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [COORD_WIDTH-1:0] dir_x_i,
  input  logic [COORD_WIDTH-1:0] dir_y_i,
  input  logic [COORD_WIDTH-1:0] dir_z_i,
  output logic                   push_o,
  input  logic                   full_i,
  output cmfuv_pkg::ctrl_t       ctrl_o,
  output logic [COORD_WIDTH:0]   num_u_o,
  output logic [COORD_WIDTH:0]   num_t_o,
  output logic [COORD_WIDTH:0]   den_o
);

  localparam int unsigned SW = COORD_WIDTH + 2;

  function automatic logic [COORD_WIDTH-1:0] mag_of(logic [COORD_WIDTH-1:0] d);
    return d[COORD_WIDTH-1] ? (~d + 1'b1) : d;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] pick(cmfuv_pkg::axis_e ax,
                                                   logic [COORD_WIDTH-1:0] x,
                                                   logic [COORD_WIDTH-1:0] y,
                                                   logic [COORD_WIDTH-1:0] z);
    unique case (ax)
      cmfuv_pkg::AXIS_X: return x;
      cmfuv_pkg::AXIS_Y: return y;
      cmfuv_pkg::AXIS_Z: return z;
      default:           return x;
    endcase
  endfunction

  logic [COORD_WIDTH-1:0] mag_x, mag_y, mag_z, mag_m;
  logic [COORD_WIDTH-1:0] d_major, d_u, d_v;
  cmfuv_pkg::axis_e       axis;
  cmfuv_pkg::face_e       face;
  logic                   major_pos;
  logic signed [SW-1:0]   m_ext, a_ext, b_ext, num_u_s, num_t_s;
  logic                   take, moved;
  logic                   valid_q, valid_d;
  cmfuv_pkg::ctrl_t       ctrl_q;
  logic [COORD_WIDTH:0]   num_u_q, num_t_q, den_q;

  always_comb begin
    mag_x = mag_of(dir_x_i);
    mag_y = mag_of(dir_y_i);
    mag_z = mag_of(dir_z_i);
    // Strict compares keep the lowest index on a tie.
    axis  = cmfuv_pkg::AXIS_X;
    mag_m = mag_x;
    if (mag_y > mag_m) begin
      axis  = cmfuv_pkg::AXIS_Y;
      mag_m = mag_y;
    end
    if (mag_z > mag_m) begin
      axis  = cmfuv_pkg::AXIS_Z;
      mag_m = mag_z;
    end
    d_major   = pick(axis, dir_x_i, dir_y_i, dir_z_i);
    major_pos = !d_major[COORD_WIDTH-1] && (d_major != '0);
    face      = cmfuv_pkg::face_e'({axis, !major_pos});
    d_u       = pick(cmfuv_pkg::face_u_axis(face), dir_x_i, dir_y_i, dir_z_i);
    d_v       = pick(cmfuv_pkg::face_v_axis(face), dir_x_i, dir_y_i, dir_z_i);
    m_ext     = $signed({2'b00, mag_m});
    a_ext     = $signed({{2{d_u[COORD_WIDTH-1]}}, d_u});
    b_ext     = $signed({{2{d_v[COORD_WIDTH-1]}}, d_v});
    num_u_s   = cmfuv_pkg::face_u_neg(face) ? (m_ext - a_ext) : (m_ext + a_ext);
    num_t_s   = cmfuv_pkg::face_v_neg(face) ? (m_ext + b_ext) : (m_ext - b_ext);
  end

  assign in_stall_o = valid_q && full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign moved      = valid_q && !full_i;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (moved) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Both numerators lie in [0, 2m], so the low COORD_WIDTH+1 bits hold them exactly.
  always_ff @(posedge clk_i) begin
    if (take) begin
      ctrl_q.face       <= face;
      ctrl_q.degenerate <= (mag_m == '0);
      num_u_q           <= num_u_s[COORD_WIDTH:0];
      num_t_q           <= num_t_s[COORD_WIDTH:0];
      den_q             <= {mag_m, 1'b0};
    end
  end

  assign push_o  = valid_q;
  assign ctrl_o  = ctrl_q;
  assign num_u_o = num_u_q;
  assign num_t_o = num_t_q;
  assign den_o   = den_q;

endmodule

[rtl/core/cmfuv_fifo.sv]
// Two-entry queue that decouples the classify front from the divider back.
`timescale 1ns / 1ps

module cmfuv_fifo #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic              wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count exceeds its depth");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> !empty_o)
    else $error("queue empty after a transfer in without one out");

endmodule

[rtl/core/cmfuv_back.sv]
// Back end: pipelined restoring dividers for u and t, saturation and the output register.
`timescale 1ns / 1ps

module cmfuv_back #(
  parameter int unsigned COORD_WIDTH  = 16,
  parameter int unsigned UV_FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    empty_i,
  output logic                    pop_o,
  input  cmfuv_pkg::ctrl_t        ctrl_i,
  input  logic [COORD_WIDTH:0]    num_u_i,
  input  logic [COORD_WIDTH:0]    num_t_i,
  input  logic [COORD_WIDTH:0]    den_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [2:0]              face_index_o,
  output logic [UV_FRAC_BITS-1:0] tex_u_o,
  output logic [UV_FRAC_BITS-1:0] tex_t_o,
  output logic                    degenerate_o
);

  localparam int unsigned NSTG = UV_FRAC_BITS + 1;
  localparam int unsigned LAST = NSTG - 1;
  localparam int unsigned QW   = UV_FRAC_BITS + 1;
  localparam int unsigned DW   = COORD_WIDTH + 1;
  localparam int unsigned RW   = COORD_WIDTH + 2;

  // One quotient bit: compare against twice the major magnitude, then double
  // the partial remainder, which keeps it below four times the magnitude.
  function automatic logic [RW:0] div_step(logic [RW-1:0] r, logic [RW-1:0] d);
    logic          ge;
    logic [RW-1:0] diff;
    ge   = (r >= d);
    diff = ge ? (r - d) : r;
    return {diff[RW-2:0], 1'b0, ge};
  endfunction

  logic             advance;
  logic             stg_valid_q [NSTG];
  cmfuv_pkg::ctrl_t stg_ctrl_q  [NSTG];
  logic [RW-1:0]    ru_q        [NSTG];
  logic [RW-1:0]    rt_q        [NSTG];
  logic [QW-1:0]    qu_q        [NSTG];
  logic [QW-1:0]    qt_q        [NSTG];
  logic [DW-1:0]    den_q       [NSTG];

  logic                    out_valid_q;
  logic [2:0]              face_q;
  logic [UV_FRAC_BITS-1:0] tex_u_q, tex_t_q, tex_u_d, tex_t_d;
  logic                    degen_q;

  assign advance = !out_valid_q || !out_stall_i;
  assign pop_o   = advance && !empty_i;

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    logic             v_in;
    cmfuv_pkg::ctrl_t c_in;
    logic [RW-1:0]    ru_in, rt_in;
    logic [QW-1:0]    qu_in, qt_in;
    logic [DW-1:0]    d_in;
    logic [RW:0]      su, st;

    if (k == 0) begin : g_first
      assign v_in  = !empty_i;
      assign c_in  = ctrl_i;
      assign ru_in = {1'b0, num_u_i};
      assign rt_in = {1'b0, num_t_i};
      assign qu_in = '0;
      assign qt_in = '0;
      assign d_in  = den_i;
    end else begin : g_next
      assign v_in  = stg_valid_q[k-1];
      assign c_in  = stg_ctrl_q[k-1];
      assign ru_in = ru_q[k-1];
      assign rt_in = rt_q[k-1];
      assign qu_in = qu_q[k-1];
      assign qt_in = qt_q[k-1];
      assign d_in  = den_q[k-1];
    end

    assign su = div_step(ru_in, {1'b0, d_in});
    assign st = div_step(rt_in, {1'b0, d_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_valid_q[k] <= 1'b0;
      end else if (advance) begin
        stg_valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        stg_ctrl_q[k] <= c_in;
        ru_q[k]       <= su[RW:1];
        rt_q[k]       <= st[RW:1];
        qu_q[k]       <= {qu_in[QW-2:0], su[0]};
        qt_q[k]       <= {qt_in[QW-2:0], st[0]};
        den_q[k]      <= d_in;
      end
    end
  end

  // A quotient of exactly one saturates to the all-ones code.
  always_comb begin
    tex_u_d = qu_q[LAST][QW-1] ? '1 : qu_q[LAST][UV_FRAC_BITS-1:0];
    tex_t_d = qt_q[LAST][QW-1] ? '1 : qt_q[LAST][UV_FRAC_BITS-1:0];
    if (stg_ctrl_q[LAST].degenerate) begin
      tex_u_d = '0;
      tex_t_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= stg_valid_q[LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      face_q  <= stg_ctrl_q[LAST].face;
      tex_u_q <= tex_u_d;
      tex_t_q <= tex_t_d;
      degen_q <= stg_ctrl_q[LAST].degenerate;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign face_index_o = face_q;
  assign tex_u_o      = tex_u_q;
  assign tex_t_o      = tex_t_q;
  assign degenerate_o = degen_q;

  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_valid_q[LAST] && !stg_ctrl_q[LAST].degenerate && qu_q[LAST][QW-1])
    |-> (qu_q[LAST][QW-2:0] == '0))
    else $error("u quotient above one");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && stg_valid_q[LAST]) |=> out_valid_q)
    else $error("finished item not moved into the output register");

endmodule

[rtl/core/cube_map_face_uv_select.sv]
// Top level of the cube map face selection and face coordinate block.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o with dir_x_i, dir_y_i, dir_z_i as
//   signed Q1.(COORD_WIDTH-1) direction components. A transfer happens at a
//   clock edge with valid high and stall low.
//   Output channel: out_valid_o / out_stall_i with face_index_o (0 +x .. 5 -z),
//   tex_u_o and tex_t_o (unsigned Q0.UV_FRAC_BITS, saturated) and degenerate_o,
//   which flags a zero vector (coordinates then zero).
//   Throughput is one direction per cycle while in_stall_o is low. With the
//   queue empty, a result passes the classify register (loaded on the transfer
//   edge), one queue write, UV_FRAC_BITS + 1 divider stages (one quotient bit
//   each for u and t) and the output register before it is valid.
//   When the receiver stalls, the divider pipeline holds, the two-entry queue
//   keeps accepting from the classify stage until it fills, and only then does
//   in_stall_o rise. Results keep their order; none is dropped.
//   Reset clears all valid flags and the queue; no item is in flight after it.
`timescale 1ns / 1ps

module cube_map_face_uv_select #(
  parameter int unsigned COORD_WIDTH  = 16,
  parameter int unsigned UV_FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [COORD_WIDTH-1:0]  dir_x_i,
  input  logic [COORD_WIDTH-1:0]  dir_y_i,
  input  logic [COORD_WIDTH-1:0]  dir_z_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [2:0]              face_index_o,
  output logic [UV_FRAC_BITS-1:0] tex_u_o,
  output logic [UV_FRAC_BITS-1:0] tex_t_o,
  output logic                    degenerate_o
);

  localparam int unsigned OPW    = COORD_WIDTH + 1;
  localparam int unsigned FIFO_W = $bits(cmfuv_pkg::ctrl_t) + 3 * OPW;

  logic               push, full, pop, empty;
  cmfuv_pkg::ctrl_t   fr_ctrl, bk_ctrl;
  logic [OPW-1:0]     fr_num_u, fr_num_t, fr_den;
  logic [OPW-1:0]     bk_num_u, bk_num_t, bk_den;
  logic [FIFO_W-1:0]  q_wr, q_rd;

  cmfuv_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .dir_x_i    (dir_x_i),
    .dir_y_i    (dir_y_i),
    .dir_z_i    (dir_z_i),
    .push_o     (push),
    .full_i     (full),
    .ctrl_o     (fr_ctrl),
    .num_u_o    (fr_num_u),
    .num_t_o    (fr_num_t),
    .den_o      (fr_den)
  );

  assign q_wr = {fr_ctrl, fr_num_u, fr_num_t, fr_den};

  cmfuv_fifo #(
    .DATA_W(FIFO_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wr),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (q_rd)
  );

  assign {bk_ctrl, bk_num_u, bk_num_t, bk_den} = q_rd;

  cmfuv_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .UV_FRAC_BITS(UV_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .pop_o        (pop),
    .ctrl_i       (bk_ctrl),
    .num_u_i      (bk_num_u),
    .num_t_i      (bk_num_t),
    .den_i        (bk_den),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .face_index_o (face_index_o),
    .tex_u_o      (tex_u_o),
    .tex_t_o      (tex_t_o),
    .degenerate_o (degenerate_o)
  );

endmodule
